// ===== hdl/dba_pkg.sv =====
package dba_pkg;

	localparam int BLK_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int FC_W    = 7;
	localparam int CMD_W   = 3;
	localparam int MAX_RES = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CONTIG  = 3'd0,
		CMD_LINKED  = 3'd1,
		CMD_INDEXED = 3'd2,
		CMD_FREE    = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_TAKE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SIZE_W-1:0] size;
		logic [BLK_W-1:0]  block;
	} in_item_t;

	typedef struct packed {
		logic [BLK_W-1:0] block_out;
		logic             is_index;
		logic             status;
		logic             last;
		logic [FC_W-1:0]  free_count;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic wb;
		logic clr_all;
		logic clr_one;
		logic set_one;
	} chain_ctl_t;

endpackage

// ===== hdl/dba_cell.sv =====
module dba_cell import dba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic shift_in,
	input  logic clr,
	input  logic set,
	output logic used
);

	logic used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (clr) begin
			used_q <= 1'b0;
		end else if (set) begin
			used_q <= 1'b1;
		end else if (shift) begin
			used_q <= shift_in;
		end
	end

	assign used = used_q;

endmodule

// ===== hdl/dba_ctrl.sv =====
module dba_ctrl import dba_pkg::*; #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  in_item_t                      item,
	input  logic                          head_used,
	input  logic                          sel_used,
	output logic                          busy,
	output chain_ctl_t                    ctl,
	output logic [$clog2(NUM_BLOCKS)-1:0] sel_idx,
	output out_item_t                     result,
	output logic                          result_stb
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int FW = $clog2(NUM_BLOCKS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

	state_t            state_q, state_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic [IW-1:0]     run_start_q, run_start_d;
	logic [SIZE_W-1:0] cnt_q, cnt_d;
	logic [SIZE_W-1:0] need_q, need_d;
	logic              found_q, found_d;
	logic              indexed_q, indexed_d;
	logic [FW-1:0]     free_q, free_d;
	out_item_t         res_q, res_d;
	logic              stb_q, stb_d;
	logic [7:0]        need_w;
	logic              size_ok;
	logic [SIZE_W-1:0] cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			stb_q     <= 1'b0;
			free_q    <= FW'(NUM_BLOCKS);
			idx_q     <= '0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			stb_q     <= stb_d;
			free_q    <= free_d;
			idx_q     <= idx_d;
			cnt_q     <= cnt_d;
			found_q   <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		run_start_q <= run_start_d;
		need_q      <= need_d;
		indexed_q   <= indexed_d;
		res_q       <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		run_start_d = run_start_q;
		cnt_d       = cnt_q;
		need_d      = need_q;
		found_d     = found_q;
		indexed_d   = indexed_q;
		free_d      = free_q;
		res_d       = res_q;
		stb_d       = 1'b0;
		ctl         = '0;
		sel_idx     = idx_q;
		cnt_inc     = cnt_q + SIZE_W'(1);
		need_w      = 8'(item.size) + ((item.cmd == CMD_INDEXED) ? 8'd1 : 8'd0);
		size_ok     = (item.size != '0) && (need_w <= 8'(MAX_RES))
		              && (32'(need_w) <= NUM_BLOCKS);

		case (state_q)
			ST_IDLE: begin
				sel_idx = IW'(item.block);
				if (start) begin
					res_d.block_out = '0;
					res_d.is_index  = 1'b0;
					res_d.status    = 1'b0;
					res_d.last      = 1'b1;
					case (item.cmd)
						CMD_FREE: begin
							if (32'(item.block) < NUM_BLOCKS) begin
								ctl.clr_one = 1'b1;
								free_d      = free_q + FW'(sel_used);
							end
							res_d.block_out  = item.block;
							res_d.free_count = FC_W'(free_d);
							stb_d            = 1'b1;
						end
						CMD_CLEAR: begin
							ctl.clr_all      = 1'b1;
							free_d           = FW'(NUM_BLOCKS);
							res_d.free_count = FC_W'(free_d);
							stb_d            = 1'b1;
						end
						CMD_CONTIG, CMD_LINKED, CMD_INDEXED: begin
							need_d    = SIZE_W'(need_w);
							indexed_d = (item.cmd == CMD_INDEXED);
							idx_d     = '0;
							cnt_d     = '0;
							found_d   = 1'b0;
							if (!size_ok || (item.cmd != CMD_CONTIG
							    && 32'(free_q) < 32'(need_w))) begin
								// no-space reply, map untouched
								res_d.status     = 1'b1;
								res_d.free_count = FC_W'(free_q);
								stb_d            = 1'b1;
							end else if (item.cmd == CMD_CONTIG) begin
								state_d = ST_RUN;
							end else begin
								state_d = ST_TAKE;
								free_d  = free_q - FW'(need_w);
							end
						end
						default: ;
					endcase
				end
			end

			// full rotation looking for the lowest free run
			ST_RUN: begin
				ctl.shift = 1'b1;
				ctl.wb    = head_used;
				if (!found_q) begin
					if (!head_used) begin
						if (cnt_q == '0) begin
							run_start_d = idx_q;
						end
						cnt_d = cnt_inc;
						if (cnt_inc == need_q) begin
							found_d = 1'b1;
						end
					end else begin
						cnt_d = '0;
					end
				end
				if (idx_q == LAST_IDX) begin
					if (found_d) begin
						state_d = ST_EMIT;
						idx_d   = run_start_d;
						cnt_d   = '0;
						free_d  = free_q - FW'(need_q);
					end else begin
						state_d          = ST_IDLE;
						res_d.block_out  = '0;
						res_d.is_index   = 1'b0;
						res_d.status     = 1'b1;
						res_d.last       = 1'b1;
						res_d.free_count = FC_W'(free_q);
						stb_d            = 1'b1;
					end
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end

			// map is home again: mark and emit the run one block per cycle
			ST_EMIT: begin
				sel_idx          = idx_q;
				ctl.set_one      = 1'b1;
				res_d.block_out  = BLK_W'(idx_q);
				res_d.is_index   = 1'b0;
				res_d.status     = 1'b0;
				res_d.last       = (cnt_inc == need_q);
				res_d.free_count = FC_W'(free_q);
				stb_d            = 1'b1;
				cnt_d            = cnt_inc;
				idx_d            = idx_q + IW'(1);
				if (cnt_inc == need_q) begin
					state_d = ST_IDLE;
				end
			end

			// take free blocks as they pass the head, keep rotating to realign
			ST_TAKE: begin
				ctl.shift = 1'b1;
				ctl.wb    = head_used;
				if (!head_used && cnt_q != need_q) begin
					ctl.wb           = 1'b1;
					res_d.block_out  = BLK_W'(idx_q);
					res_d.is_index   = indexed_q && (cnt_q == '0);
					res_d.status     = 1'b0;
					res_d.last       = (cnt_inc == need_q);
					res_d.free_count = FC_W'(free_q);
					stb_d            = 1'b1;
					cnt_d            = cnt_inc;
				end
				if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign result     = res_q;
	assign result_stb = stb_q;

endmodule

// ===== hdl/disk_block_allocator_unit.sv =====
// Block allocator over a used-bit map of NUM_BLOCKS blocks, all free after reset. Items are
// taken when start is high and busy is low. Free, clear-all and an allocation that is out of
// range, or a linked or indexed one that asks for more blocks than are free, answer with one
// result in the cycle after the item. Linked and indexed allocation rotate the map once through
// a ring of one-bit cells past a single head, and the blocks come out as they pass the head.
// Contiguous allocation first rotates the ring once to find the lowest free run; if no run is
// long enough its no-space result follows that rotation, otherwise it marks and emits the run
// one block per cycle. Each result is on the result port for one cycle while result_stb is
// high; the receiver cannot stall and must take it then.
module disk_block_allocator_unit import dba_pkg::*; #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output out_item_t result,
	output logic      result_stb
);

	localparam int IW = $clog2(NUM_BLOCKS);

	logic [NUM_BLOCKS-1:0] used_vec;
	chain_ctl_t            ctl;
	logic [IW-1:0]         sel_idx;
	logic                  sel_used;

	assign sel_used = used_vec[sel_idx];

	dba_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.head_used (used_vec[0]),
		.sel_used  (sel_used),
		.busy      (busy),
		.ctl       (ctl),
		.sel_idx   (sel_idx),
		.result    (result),
		.result_stb(result_stb)
	);

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		logic shift_in;
		logic clr;
		logic set;

		// ring: the head writes block 0 back at the tail
		if (i == NUM_BLOCKS - 1) begin : g_tail
			assign shift_in = ctl.wb;
		end else begin : g_mid
			assign shift_in = used_vec[i+1];
		end

		assign clr = ctl.clr_all || (ctl.clr_one && sel_idx == IW'(i));
		assign set = ctl.set_one && sel_idx == IW'(i);

		dba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (ctl.shift),
			.shift_in(shift_in),
			.clr     (clr),
			.set     (set),
			.used    (used_vec[i])
		);
	end

endmodule

// ===== bench/disk_block_allocator_unit_checker.sv =====
module disk_block_allocator_unit_checker import dba_pkg::*; #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  item,
	input  out_item_t result,
	input  logic      result_stb,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [NUM_BLOCKS-1:0] block_used = '0;
	out_item_t             grant_queue[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [FC_W-1:0] free_blocks();
		int n;
		n = 0;
		for (int i = 0; i < NUM_BLOCKS; i++)
			if (!block_used[i])
				n++;
		return FC_W'(n);
	endfunction

	function automatic void push_grant(int blk, logic idx, logic st, logic lst,
			logic [FC_W-1:0] fc);
		out_item_t r;
		r.block_out = BLK_W'(blk);
		r.is_index = idx;
		r.status = st;
		r.last = lst;
		r.free_count = fc;
		grant_queue.insert(grant_queue.size(), r);
	endfunction

	function automatic void predict_allocation(in_item_t req);
		int need;
		int run;
		int first;
		int i;
		int picks[$];
		logic [FC_W-1:0] fc;
		case (req.cmd)
			CMD_FREE: begin
				if (int'(req.block) < NUM_BLOCKS)
					block_used[req.block] = 1'b0;
				push_grant(int'(req.block), 1'b0, 1'b0, 1'b1, free_blocks());
			end
			CMD_CLEAR: begin
				block_used = '0;
				push_grant(0, 1'b0, 1'b0, 1'b1, free_blocks());
			end
			CMD_CONTIG, CMD_LINKED, CMD_INDEXED: begin
				need = int'(req.size) + ((req.cmd == CMD_INDEXED) ? 1 : 0);
				if (req.size != 0 && need <= MAX_RES && need <= NUM_BLOCKS) begin
					if (req.cmd == CMD_CONTIG) begin
						// lowest free run that is long enough
						run = 0;
						first = 0;
						for (i = 0; i < NUM_BLOCKS && run < need; i++) begin
							if (!block_used[i]) begin
								if (run == 0)
									first = i;
								run++;
							end else begin
								run = 0;
							end
						end
						if (run == need)
							for (i = 0; i < need; i++)
								picks.insert(picks.size(), first + i);
					end else if (int'(free_blocks()) >= need) begin
						for (i = 0; i < NUM_BLOCKS && picks.size() < need; i++)
							if (!block_used[i])
								picks.insert(picks.size(), i);
					end
				end
				if (picks.size() == 0) begin
					push_grant(0, 1'b0, 1'b1, 1'b1, free_blocks());
				end else begin
					foreach (picks[k])
						block_used[picks[k]] = 1'b1;
					fc = free_blocks();
					foreach (picks[k])
						push_grant(picks[k], (req.cmd == CMD_INDEXED) && (k == 0), 1'b0,
							k == picks.size() - 1, fc);
				end
			end
			default: begin
				// undefined codes leave the map alone and give no result
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			// compare before predicting: a result never belongs to the item taken at this edge
			if (result_stb) begin
				if (grant_queue.size() == 0) begin
					$error("result with no item outstanding: block_out %0d", result.block_out);
					fail_count++;
				end else begin
					want = grant_queue.pop_front();
					check_field("block_out", 8'(want.block_out), 8'(result.block_out));
					check_field("is_index", 8'(want.is_index), 8'(result.is_index));
					check_field("status", 8'(want.status), 8'(result.status));
					check_field("last", 8'(want.last), 8'(result.last));
					check_field("free_count", 8'(want.free_count), 8'(result.free_count));
				end
			end
			if (start && !busy)
				predict_allocation(item);
			pending <= grant_queue.size();
		end
	end

endmodule

// ===== bench/disk_block_allocator_unit_tb.sv =====
module disk_block_allocator_unit_tb;
	import dba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS = 64;
	localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 100;
	localparam logic [CMD_W-1:0] CMD_FIRST_UNDEF = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LAST_UNDEF = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	out_item_t result;
	logic      result_stb;
	int        fail_count;
	int        pending;
	int        cycles = 0;
	bit        steady = 1'b0;

	disk_block_allocator_unit #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_stb(result_stb)
	);

	disk_block_allocator_unit_checker #(.NUM_BLOCKS(NUM_BLOCKS)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_stb(result_stb),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic in_item_t pack_request(logic [CMD_W-1:0] cmd, int size, int blk);
		in_item_t r;
		r.cmd = cmd;
		r.size = SIZE_W'(size);
		r.block = BLK_W'(blk);
		return r;
	endfunction

	function automatic in_item_t random_request();
		in_item_t r;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 24)
			r.cmd = CMD_CONTIG;
		else if (sel < 44)
			r.cmd = CMD_LINKED;
		else if (sel < 64)
			r.cmd = CMD_INDEXED;
		else if (sel < 88)
			r.cmd = CMD_FREE;
		else if (sel < 92)
			r.cmd = CMD_CLEAR;
		else
			r.cmd = CMD_W'($urandom_range(CMD_FIRST_UNDEF, CMD_LAST_UNDEF));
		// mostly small requests so the map fragments rather than filling at once
		sel = $urandom_range(0, 99);
		if (sel < 70)
			r.size = SIZE_W'($urandom_range(1, 6));
		else if (sel < 90)
			r.size = SIZE_W'($urandom_range(7, 40));
		else if (sel < 95)
			r.size = SIZE_W'($urandom_range(41, 64));
		else
			r.size = SIZE_W'($urandom_range(0, 127));
		if ($urandom_range(0, 1))
			r.block = BLK_W'($urandom_range(0, 15));
		else
			r.block = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
		return r;
	endfunction

	task automatic send_request(input in_item_t req, input bit drain_first);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0 || drain_first)
			start <= 1'b0;
		// hold off until every outstanding result has been seen
		if (drain_first)
			do @(posedge clk); while (pending != 0);
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		item <= req;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int counted;
		in_item_t req;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(pack_request(CMD_CONTIG, 1, 0), 1'b0);
		send_request(pack_request(CMD_LINKED, 3, 63), 1'b0);
		send_request(pack_request(CMD_INDEXED, 2, 0), 1'b0);
		// hole of one block inside the used area
		send_request(pack_request(CMD_FREE, 0, 1), 1'b0);
		send_request(pack_request(CMD_CONTIG, 2, 0), 1'b0);
		send_request(pack_request(CMD_LINKED, 1, 0), 1'b0);
		send_request(pack_request(CMD_CONTIG, 0, 0), 1'b0);
		send_request(pack_request(CMD_CONTIG, 64, 0), 1'b0);
		send_request(pack_request(CMD_CLEAR, 127, 63), 1'b0);
		send_request(pack_request(CMD_CONTIG, 64, 0), 1'b0);
		send_request(pack_request(CMD_LINKED, 1, 0), 1'b0);
		send_request(pack_request(CMD_FREE, 0, 63), 1'b0);
		send_request(pack_request(CMD_FREE, 0, 63), 1'b0);
		send_request(pack_request(CMD_FREE, 0, 0), 1'b0);
		send_request(pack_request(CMD_CLEAR, 0, 0), 1'b0);
		send_request(pack_request(CMD_INDEXED, 63, 0), 1'b0);
		send_request(pack_request(CMD_CLEAR, 0, 0), 1'b0);
		send_request(pack_request(CMD_INDEXED, 64, 0), 1'b0);
		send_request(pack_request(CMD_LINKED, 64, 0), 1'b0);
		send_request(pack_request(CMD_CLEAR, 0, 0), 1'b0);
		send_request(pack_request(CMD_CONTIG, 127, 0), 1'b0);
		send_request(pack_request(CMD_LINKED, 65, 0), 1'b0);
		for (int c = CMD_FIRST_UNDEF; c <= CMD_LAST_UNDEF; c++)
			send_request(pack_request(CMD_W'(c), 85, 42), 1'b0);
		send_request(pack_request(CMD_FREE, 42, 42), 1'b0);
		send_request(pack_request(CMD_FREE, 21, 21), 1'b1);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 16 == 0)
				steady = ($urandom_range(0, 3) == 0);
			req = random_request();
			send_request(req, $urandom_range(0, 24) == 0);
			if (req.cmd <= CMD_CLEAR)
				counted++;
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
